FILE: sv/anchor_line_of_sight_check_core_assert.svh
// Assertion helpers, clocked on clk_i and off during reset
`ifndef ANCHOR_LINE_OF_SIGHT_CHECK_CORE_ASSERT_SVH
`define ANCHOR_LINE_OF_SIGHT_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define ALOS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/alos_pkg.sv
package alos_pkg;

  localparam int unsigned NumBeamsDef = 1024;
  localparam int unsigned CordicIters = 16;

  localparam logic signed [20:0] PiQ16 = 21'sd205887;

  localparam logic [16:0] AtanQ16 [CordicIters] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
  };

  // visibility codes
  localparam logic [1:0] VisOut  = 2'd0;
  localparam logic [1:0] VisLos  = 2'd1;
  localparam logic [1:0] VisNlos = 2'd2;

  // config register indexes
  localparam logic [2:0] RegSensorX  = 3'd0;
  localparam logic [2:0] RegSensorY  = 3'd1;
  localparam logic [2:0] RegSensorZ  = 3'd2;
  localparam logic [2:0] RegAngleMin = 3'd3;
  localparam logic [2:0] RegAngleMax = 3'd4;
  localparam logic [2:0] RegAngleStep = 3'd5;

  localparam int unsigned ProdW = 50;

endpackage

FILE: sv/alos_ram.sv
module alos_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/alos_mul.sv
// Registered 25x25 signed multiplier
module alos_mul (
  input  logic                             clk_i,
  input  logic signed [24:0]               a_i,
  input  logic signed [24:0]               b_i,
  output logic signed [alos_pkg::ProdW-1:0] p_o
);
  import alos_pkg::*;

  logic signed [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: sv/anchor_line_of_sight_check_core.sv
// Load item (cmd 0): written at the accept edge, no result; loads run back to back.
// Query item (cmd 1): INIT, 16 CORDIC steps (skipped when dx = dy = 0) and window check;
// outside the window the result follows, else 20 divide, index, 5 multiply and compare
// steps, plus 25 sqrt steps if clear. Not ready meanwhile; ready for the next item once
// the result is registered, later while a result stalls.
// rst_ni async low: config to defaults, sequencer idle, no result; range memory kept.
module anchor_line_of_sight_check_core #(
  parameter int unsigned NUM_BEAMS = alos_pkg::NumBeamsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [9:0] beam_index, [33:10] range_value, [49:34] anchor_id,
  // [73:50] anchor_x, [97:74] anchor_y, [121:98] anchor_z, [127:122] zero
  input  logic [127:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] result_id, [25:16] hit_beam, [50:26] distance, [55:51] zero
  output logic [55:0]  m_axis_tdata,
  // [1:0] visibility
  output logic [1:0]   m_axis_tuser
);
  import alos_pkg::*;

  localparam int unsigned IW = (NUM_BEAMS > 1) ? $clog2(NUM_BEAMS) : 1;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_CORD = 4'd2;
  localparam logic [3:0] S_WIN  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_IDX  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  // ---------------- configuration registers ----------------
  logic signed [23:0] sx_q, sy_q, sz_q;
  logic signed [18:0] amin_q, amax_q;
  logic [18:0]        step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      sz_q   <= 24'sd500;
      amin_q <= -19'sd205887;
      amax_q <= 19'sd205887;
      step_q <= 19'd402;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSensorX:   sx_q   <= cfg_data_i;
        RegSensorY:   sy_q   <= cfg_data_i;
        RegSensorZ:   sz_q   <= cfg_data_i;
        RegAngleMin:  amin_q <= cfg_data_i[18:0];
        RegAngleMax:  amax_q <= cfg_data_i[18:0];
        RegAngleStep: step_q <= cfg_data_i[18:0];
        default: ;
      endcase
    end
  end

  // ---------------- input unpack ----------------
  logic               in_cmd;
  logic [9:0]         in_beam;
  logic [23:0]        in_range;
  logic [15:0]        in_id;
  logic signed [23:0] in_ax, in_ay, in_az;
  logic               in_acc;

  assign in_cmd   = s_axis_tuser;
  assign in_beam  = s_axis_tdata[9:0];
  assign in_range = s_axis_tdata[33:10];
  assign in_id    = s_axis_tdata[49:34];
  assign in_ax    = s_axis_tdata[73:50];
  assign in_ay    = s_axis_tdata[97:74];
  assign in_az    = s_axis_tdata[121:98];

  logic [3:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------- range memory ----------------
  logic [IW+9:0] beam_ext;
  logic          beam_ok;
  logic          ram_we;
  logic [IW-1:0] idx_q;
  logic [23:0]   rng_rd;

  assign beam_ext = {{IW{1'b0}}, in_beam};
  assign beam_ok  = (32'(in_beam) < 32'(NUM_BEAMS));   // loads past the table are dropped
  assign ram_we   = in_acc && !in_cmd && beam_ok;

  alos_ram #(
    .Width (24),
    .Depth (NUM_BEAMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (beam_ext[IW-1:0]),
    .wdata_i (in_range),
    .raddr_i (idx_q),
    .rdata_o (rng_rd)
  );

  // ---------------- datapath registers ----------------
  logic signed [24:0] dx_q, dy_q, dz_q;
  logic [15:0]        id_q;
  logic signed [35:0] x_q, y_q;
  logic signed [20:0] z_q;
  logic [19:0]        nq_q;     // dividend shifting out, quotient shifting in
  logic [19:0]        rem_q;
  logic [ProdW-1:0]   sum_q, rsq_q;
  logic [23:0]        rng_q;
  logic [50:0]        sv_q, root_q;
  logic [1:0]         res_vis_q;
  logic [24:0]        res_dist_q;

  // ---------------- shared multiplier ----------------
  logic signed [24:0]       mul_a;
  logic signed [ProdW-1:0]  mul_p;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    mul_a = dx_q;
      2'd1:    mul_a = dy_q;
      2'd2:    mul_a = dz_q;
      default: mul_a = $signed({1'b0, rng_rd});
    endcase
  end

  alos_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_a),
    .p_o   (mul_p)
  );

  // ---------------- step logic ----------------
  logic signed [20:0] amin_ext, amax_ext;
  logic [18:0]        step_eff;
  logic               out_win;
  logic [24:0]        dx_abs;
  logic signed [35:0] dy_sh;
  logic signed [35:0] xs, ys;
  logic signed [20:0] t_ext;
  logic [19:0]        div_trial;
  logic               div_ge;
  logic               clamp;
  logic [50:0]        sq_bit, sq_trial;
  logic               sq_ge;
  logic [IW+9:0]      hit_ext;
  logic               out_load;

  assign amin_ext = {{2{amin_q[18]}}, amin_q};
  assign amax_ext = {{2{amax_q[18]}}, amax_q};
  assign step_eff = (step_q == '0) ? 19'd1 : step_q;
  assign out_win  = (z_q < amin_ext) || (z_q > amax_ext);
  assign dx_abs   = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
  assign dy_sh    = {{3{dy_q[24]}}, dy_q, 8'b0};
  assign xs       = x_q >>> cnt_q[3:0];
  assign ys       = y_q >>> cnt_q[3:0];
  assign t_ext    = $signed({4'b0, AtanQ16[cnt_q[3:0]]});
  assign div_trial = {rem_q[18:0], nq_q[19]};
  assign div_ge    = (div_trial >= {1'b0, step_eff});
  assign clamp     = (32'(nq_q) > 32'(NUM_BEAMS - 1));
  assign sq_bit    = 51'(1) << (6'd48 - {cnt_q, 1'b0});
  assign sq_trial  = root_q + sq_bit;
  assign sq_ge     = (sv_q >= sq_trial);
  assign hit_ext   = {10'b0, idx_q};

  logic         out_valid_q;
  logic [15:0]  out_id_q;
  logic [1:0]   out_vis_q;
  logic [9:0]   out_hit_q;
  logic [24:0]  out_dist_q;

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_cmd) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cnt_d   = '0;
        // zero offset in the plane: bearing is zero, no rotation
        state_d = (dx_q == '0 && dy_q == '0) ? S_WIN : S_CORD;
      end
      S_CORD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CordicIters - 1)) begin
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        cnt_d   = '0;
        state_d = out_win ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd19) begin
          state_d = S_IDX;
        end
      end
      S_IDX: begin
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd4) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cnt_d   = '0;
        state_d = (rsq_q < sum_q) ? S_DONE : S_SQRT;
      end
      S_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd24) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd) begin
      id_q <= in_id;
      dx_q <= 25'(in_ax) - 25'(sx_q);
      dy_q <= 25'(in_ay) - 25'(sy_q);
      dz_q <= 25'(in_az) - 25'(sz_q);
    end
    unique case (state_q)
      S_INIT: begin
        x_q <= $signed({3'b0, dx_abs, 8'b0});
        y_q <= dx_q[24] ? -dy_sh : dy_sh;
        if (dx_q[24]) begin
          z_q <= dy_q[24] ? -PiQ16 : PiQ16;
        end else begin
          z_q <= '0;
        end
      end
      S_CORD: begin
        if (!y_q[35]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + t_ext;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - t_ext;
        end
      end
      S_WIN: begin
        nq_q       <= 20'(z_q - amin_ext);
        rem_q      <= '0;
        res_vis_q  <= VisOut;
        res_dist_q <= '0;
        idx_q      <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? (div_trial - 20'(step_eff)) : div_trial;
        nq_q  <= {nq_q[18:0], div_ge};
      end
      S_IDX: begin
        idx_q <= clamp ? IW'(NUM_BEAMS - 1) : nq_q[IW-1:0];
        sum_q <= '0;
      end
      S_MUL: begin
        if (cnt_q >= 5'd1 && cnt_q <= 5'd3) begin
          sum_q <= sum_q + mul_p;
        end
        if (cnt_q == 5'd4) begin
          rsq_q <= mul_p;
          rng_q <= rng_rd;
        end
      end
      S_CMP: begin
        sv_q   <= {1'b0, sum_q};
        root_q <= '0;
        if (rsq_q < sum_q) begin
          res_vis_q  <= VisNlos;
          res_dist_q <= {1'b0, rng_q};
        end else begin
          res_vis_q <= VisLos;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          sv_q   <= sv_q - sq_trial;
          root_q <= (root_q >> 1) + sq_bit;
        end else begin
          root_q <= root_q >> 1;
        end
        if (cnt_q == 5'd24) begin
          res_dist_q <= sq_ge ? 25'((root_q >> 1) + sq_bit) : 25'(root_q >> 1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_id_q   <= id_q;
      out_vis_q  <= res_vis_q;
      out_hit_q  <= hit_ext[9:0];
      out_dist_q <= res_dist_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_vis_q;
  assign m_axis_tdata  = {5'b0, out_dist_q, out_hit_q, out_id_q};

  // ---------------- checks ----------------
`include "anchor_line_of_sight_check_core_assert.svh"

  `ALOS_ASSERT(a_vis_code, m_axis_tvalid, m_axis_tuser != 2'd3, "bad visibility code")
  `ALOS_ASSERT(a_out_zero, m_axis_tvalid && m_axis_tuser == VisOut,
               m_axis_tdata[50:16] == '0, "out-of-window result not zeroed")
  `ALOS_ASSERT(a_div_rem, state_q == S_IDX, rem_q < 20'(step_eff), "divide remainder too big")
  `ALOS_ASSERT_NEXT(a_load_one, in_acc && !in_cmd, state_q == S_IDLE, "load left idle")

endmodule
